### sv/tsf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsf_pkg
// Shared types, widths and helpers for the triangle slope filter.
// ----------------------------------------------------------------------------
package tsf_pkg;

  localparam int VERTEX_DEPTH = 4096;
  localparam int COORD_W      = 16;

  localparam int IDX_W  = 12;
  localparam int ADDR_W = $clog2(VERTEX_DEPTH);
  localparam int CFG_W  = 17;
  localparam int FRAC_W = 16;

  localparam logic [CFG_W-1:0] MIN_COS_RESET = CFG_W'(32768);

  localparam logic OP_WRITE    = 1'b0;
  localparam logic OP_TRIANGLE = 1'b1;

  localparam int EDGE_W = COORD_W + 1;
  localparam int PROD_W = 2 * EDGE_W;
  localparam int N_W    = PROD_W + 1;
  localparam int MAG_W  = 2 * COORD_W + 1;
  localparam int LO_W   = (MAG_W + 1) / 2;
  localparam int HI_W   = MAG_W - LO_W;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int SUM_W  = SQ_W + 2;
  localparam int SL_W   = (SUM_W + 1) / 2;
  localparam int SH_W   = SUM_W - SL_W;
  localparam int RHS_W  = SUM_W + CFG_W;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } vertex_t;

  localparam int VERTEX_W = $bits(vertex_t);

  typedef struct packed {
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    logic [IDX_W-1:0] c;
  } corners_t;

  typedef struct packed {
    logic [2*LO_W-1:0]        ll;
    logic [HI_W+LO_W-1:0]     hl;
    logic [2*HI_W-1:0]        hh;
  } sq_parts_t;

  function automatic logic slot_in_range(input logic [IDX_W-1:0] slot);
    return 32'(slot) < VERTEX_DEPTH;
  endfunction

  function automatic logic [MAG_W-1:0] magnitude(input logic signed [N_W-1:0] v);
    logic signed [N_W-1:0] p;
    p = v[N_W-1] ? -v : v;
    return p[MAG_W-1:0];
  endfunction

  function automatic sq_parts_t square_parts(input logic [MAG_W-1:0] m);
    sq_parts_t r;
    logic [LO_W-1:0] lo;
    logic [HI_W-1:0] hi;
    lo   = m[LO_W-1:0];
    hi   = m[MAG_W-1:LO_W];
    r.ll = (2*LO_W)'(lo) * (2*LO_W)'(lo);
    r.hl = (HI_W+LO_W)'(hi) * (HI_W+LO_W)'(lo);
    r.hh = (2*HI_W)'(hi) * (2*HI_W)'(hi);
    return r;
  endfunction

  function automatic logic [SQ_W-1:0] square_join(input sq_parts_t p);
    return (SQ_W'(p.hh) << (2*LO_W)) + (SQ_W'(p.hl) << (LO_W+1)) + SQ_W'(p.ll);
  endfunction

endpackage

### sv/tsf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsf_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module tsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### sv/triangle_slope_filter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_slope_filter_core
// Stores vertices and classifies triangles as walkable or too steep.
// ----------------------------------------------------------------------------
// A vertex write does not raise busy; a triangle reads its three corners one
// after another from the single-ported vertex memory, so busy is high in the
// FETCH_B and FETCH_C states after a triangle transfer. The arithmetic after
// the reads is a seven-stage pipeline, so the keep result and the echoed
// corners appear on the result ports, marked by result_valid for one cycle.
// The receiver cannot stall and every result must be taken when shown.
// min_cos_squared is written through the cfg channel, which is always ready;
// write it only while no triangle is in flight.
module triangle_slope_filter_core
  import tsf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               operation,
  input  logic [IDX_W-1:0]   vertex_slot,
  input  logic signed [15:0] coord_x,
  input  logic signed [15:0] coord_y,
  input  logic signed [15:0] coord_z,
  input  logic [IDX_W-1:0]   corner_a,
  input  logic [IDX_W-1:0]   corner_b,
  input  logic [IDX_W-1:0]   corner_c,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CFG_W-1:0]   cfg_data,
  output logic               result_valid,
  output logic               keep,
  output logic [IDX_W-1:0]   out_corner_a,
  output logic [IDX_W-1:0]   out_corner_b,
  output logic [IDX_W-1:0]   out_corner_c
);

  typedef enum logic [1:0] {
    FETCH_IDLE,
    FETCH_B,
    FETCH_C
  } fetch_state_t;

  fetch_state_t      state;
  logic              accept;
  logic              c_arrive;
  logic [CFG_W-1:0]  min_cos;

  corners_t          cur;
  logic              ok_a;
  logic              ok_b;
  logic              ok_c;
  vertex_t           va;
  vertex_t           vb;
  vertex_t           vc;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  vertex_t           ram_wdata;
  logic [VERTEX_W-1:0] ram_rdata;

  // pipeline stages
  logic                     s1_valid;
  corners_t                 s1_tag;
  logic signed [EDGE_W-1:0] e1x, e1y, e1z, e2x, e2y, e2z;

  logic                     s2_valid;
  corners_t                 s2_tag;
  logic signed [PROD_W-1:0] px0, px1, py0, py1, pz0, pz1;

  logic                     s3_valid;
  corners_t                 s3_tag;
  logic [MAG_W-1:0]         mx, my, mz;

  logic                     s4_valid;
  corners_t                 s4_tag;
  sq_parts_t                qx, qy, qz;

  logic                     s5_valid;
  corners_t                 s5_tag;
  logic [SQ_W-1:0]          sq_z;
  logic [SUM_W-1:0]         sum_sq;

  logic                     s6_valid;
  corners_t                 s6_tag;
  logic [RHS_W-1:0]         lhs;
  logic [SL_W+CFG_W-1:0]    rp_lo;
  logic [SH_W+CFG_W-1:0]    rp_hi;

  logic [RHS_W-1:0]         rhs;

  assign busy      = (state != FETCH_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      min_cos <= MIN_COS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      min_cos <= cfg_data;
    end
  end

  // vertex memory port
  assign ram_wdata.x = COORD_W'($unsigned(coord_x));
  assign ram_wdata.y = COORD_W'($unsigned(coord_y));
  assign ram_wdata.z = COORD_W'($unsigned(coord_z));
  assign ram_we = accept && (operation == OP_WRITE) && slot_in_range(vertex_slot);

  always_comb begin
    case (state)
      FETCH_B: ram_addr = ADDR_W'(cur.b);
      FETCH_C: ram_addr = ADDR_W'(cur.c);
      default: ram_addr = (operation == OP_TRIANGLE) ? ADDR_W'(corner_a)
                                                     : ADDR_W'(vertex_slot);
    endcase
  end

  tsf_ram #(
    .WIDTH(VERTEX_W),
    .DEPTH(VERTEX_DEPTH)
  ) u_vertex_ram (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  // read sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= FETCH_IDLE;
      c_arrive <= 1'b0;
    end else begin
      c_arrive <= (state == FETCH_C);
      case (state)
        FETCH_IDLE: begin
          if (accept && (operation == OP_TRIANGLE)) begin
            state <= FETCH_B;
          end
        end
        FETCH_B: state <= FETCH_C;
        FETCH_C: state <= FETCH_IDLE;
        default: state <= FETCH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (operation == OP_TRIANGLE)) begin
      cur.a <= corner_a;
      cur.b <= corner_b;
      cur.c <= corner_c;
      ok_a  <= slot_in_range(corner_a);
      ok_b  <= slot_in_range(corner_b);
      ok_c  <= slot_in_range(corner_c);
    end
    if (state == FETCH_B) begin
      va <= ok_a ? vertex_t'(ram_rdata) : '0;
    end
    if (state == FETCH_C) begin
      vb <= ok_b ? vertex_t'(ram_rdata) : '0;
    end
  end

  assign vc = ok_c ? vertex_t'(ram_rdata) : '0;

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
      s4_valid     <= 1'b0;
      s5_valid     <= 1'b0;
      s6_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      s1_valid     <= c_arrive;
      s2_valid     <= s1_valid;
      s3_valid     <= s2_valid;
      s4_valid     <= s3_valid;
      s5_valid     <= s4_valid;
      s6_valid     <= s5_valid;
      result_valid <= s6_valid;
    end
  end

  assign rhs = (RHS_W'(rp_hi) << SL_W) + RHS_W'(rp_lo);

  // datapath
  always_ff @(posedge clk) begin
    // edges
    s1_tag <= cur;
    e1x    <= EDGE_W'(vb.x) - EDGE_W'(va.x);
    e1y    <= EDGE_W'(vb.y) - EDGE_W'(va.y);
    e1z    <= EDGE_W'(vb.z) - EDGE_W'(va.z);
    e2x    <= EDGE_W'(vc.x) - EDGE_W'(va.x);
    e2y    <= EDGE_W'(vc.y) - EDGE_W'(va.y);
    e2z    <= EDGE_W'(vc.z) - EDGE_W'(va.z);

    // cross product terms
    s2_tag <= s1_tag;
    px0    <= PROD_W'(e1y) * PROD_W'(e2z);
    px1    <= PROD_W'(e1z) * PROD_W'(e2y);
    py0    <= PROD_W'(e1z) * PROD_W'(e2x);
    py1    <= PROD_W'(e1x) * PROD_W'(e2z);
    pz0    <= PROD_W'(e1x) * PROD_W'(e2y);
    pz1    <= PROD_W'(e1y) * PROD_W'(e2x);

    // normal magnitudes
    s3_tag <= s2_tag;
    mx     <= magnitude(N_W'(px0) - N_W'(px1));
    my     <= magnitude(N_W'(py0) - N_W'(py1));
    mz     <= magnitude(N_W'(pz0) - N_W'(pz1));

    // square partial products
    s4_tag <= s3_tag;
    qx     <= square_parts(mx);
    qy     <= square_parts(my);
    qz     <= square_parts(mz);

    // squares and |n|^2
    s5_tag <= s4_tag;
    sq_z   <= square_join(qz);
    sum_sq <= SUM_W'(square_join(qx)) + SUM_W'(square_join(qy))
              + SUM_W'(square_join(qz));

    // nz^2 scaled and threshold partial products
    s6_tag <= s5_tag;
    lhs    <= RHS_W'(sq_z) << FRAC_W;
    rp_lo  <= (SL_W+CFG_W)'(sum_sq[SL_W-1:0]) * (SL_W+CFG_W)'(min_cos);
    rp_hi  <= (SH_W+CFG_W)'(sum_sq[SUM_W-1:SL_W]) * (SH_W+CFG_W)'(min_cos);

    // compare
    keep         <= (lhs >= rhs);
    out_corner_a <= s6_tag.a;
    out_corner_b <= s6_tag.b;
    out_corner_c <= s6_tag.c;
  end

endmodule

### tb/triangle_slope_filter_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_slope_filter_core_tb
// Self-checking test of the triangle slope filter. Vertices are loaded into
// the vertex memory, then triangles built from loaded vertices are classified
// under several slope limits. A behavioral copy of the vertex memory and an
// exact wide-integer form of the slope test predict keep and the echoed
// corners; every result strobe is compared against the oldest prediction.
// ----------------------------------------------------------------------------
module triangle_slope_filter_core_tb
  import tsf_pkg::*;
();

  localparam int SETTLE_CYCLES  = 12;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic     keep;
    corners_t corners;
  } verdict_t;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      start;
  logic                      busy;
  logic                      operation;
  logic [IDX_W-1:0]          vertex_slot;
  logic signed [COORD_W-1:0] coord_x;
  logic signed [COORD_W-1:0] coord_y;
  logic signed [COORD_W-1:0] coord_z;
  logic [IDX_W-1:0]          corner_a;
  logic [IDX_W-1:0]          corner_b;
  logic [IDX_W-1:0]          corner_c;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_W-1:0]          cfg_data;
  logic                      result_valid;
  logic                      keep_flag;
  logic [IDX_W-1:0]          out_corner_a;
  logic [IDX_W-1:0]          out_corner_b;
  logic [IDX_W-1:0]          out_corner_c;

  vertex_t          mesh [VERTEX_DEPTH];
  bit               vertex_written [VERTEX_DEPTH];
  int               written_slots [$];
  logic [CFG_W-1:0] min_cos_model = MIN_COS_RESET;
  verdict_t         verdicts [$];
  verdict_t         due_verdict;
  int               mismatch_count = 0;
  int               quiet_cycles = 0;

  triangle_slope_filter_core DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .operation    (operation),
    .vertex_slot  (vertex_slot),
    .coord_x      (coord_x),
    .coord_y      (coord_y),
    .coord_z      (coord_z),
    .corner_a     (corner_a),
    .corner_b     (corner_b),
    .corner_c     (corner_c),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .keep         (keep_flag),
    .out_corner_a (out_corner_a),
    .out_corner_b (out_corner_b),
    .out_corner_c (out_corner_c)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [127:0] square_mag(input longint v);
    logic [63:0] m;
    m = (v < 0) ? 64'(-v) : 64'(v);
    return 128'(m) * 128'(m);
  endfunction

  // exact test: nz^2 * 2^16 >= min_cos_squared * |n|^2
  function automatic logic slope_ok(input corners_t corners);
    longint       ax, ay, az, e1x, e1y, e1z, e2x, e2y, e2z;
    logic [127:0] sz, lhs, rhs;
    ax  = longint'($signed(mesh[corners.a].x));
    ay  = longint'($signed(mesh[corners.a].y));
    az  = longint'($signed(mesh[corners.a].z));
    e1x = longint'($signed(mesh[corners.b].x)) - ax;
    e1y = longint'($signed(mesh[corners.b].y)) - ay;
    e1z = longint'($signed(mesh[corners.b].z)) - az;
    e2x = longint'($signed(mesh[corners.c].x)) - ax;
    e2y = longint'($signed(mesh[corners.c].y)) - ay;
    e2z = longint'($signed(mesh[corners.c].z)) - az;
    sz  = square_mag(e1x * e2y - e1y * e2x);
    lhs = sz << FRAC_W;
    rhs = (square_mag(e1y * e2z - e1z * e2y) + square_mag(e1z * e2x - e1x * e2z) + sz)
          * 128'(min_cos_model);
    return lhs >= rhs;
  endfunction

  function automatic logic [IDX_W-1:0] pick_slot();
    return IDX_W'(written_slots[$urandom_range(0, written_slots.size() - 1)]);
  endfunction

  function automatic logic signed [COORD_W-1:0] random_coord();
    logic signed [COORD_W-1:0] v;
    v = COORD_W'($urandom);
    if ($urandom_range(0, 1) == 1) begin
      v = v >>> $urandom_range(0, COORD_W - 1);
    end
    return v;
  endfunction

  task automatic send_item(input logic op, input logic [IDX_W-1:0] slot,
                           input logic signed [COORD_W-1:0] x, y, z,
                           input corners_t corners, input bit idle_ok);
    verdict_t verdict;
    if (idle_ok && $urandom_range(0, 99) < 14) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start       <= 1'b1;
    operation   <= op;
    vertex_slot <= slot;
    coord_x     <= x;
    coord_y     <= y;
    coord_z     <= z;
    corner_a    <= corners.a;
    corner_b    <= corners.b;
    corner_c    <= corners.c;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (op == OP_WRITE) begin
      mesh[slot] = {x, y, z};
      if (!vertex_written[slot]) begin
        vertex_written[slot] = 1'b1;
        written_slots.insert(written_slots.size(), int'(slot));
      end
    end else begin
      verdict.keep    = slope_ok(corners);
      verdict.corners = corners;
      verdicts.insert(verdicts.size(), verdict);
    end
  endtask

  task automatic write_vertex(input logic [IDX_W-1:0] slot,
                              input logic signed [COORD_W-1:0] x, y, z,
                              input bit idle_ok);
    send_item(OP_WRITE, slot, x, y, z, corners_t'(($bits(corners_t))'($urandom)), idle_ok);
  endtask

  task automatic classify(input logic [IDX_W-1:0] a, b, c, input bit idle_ok);
    corners_t corners;
    corners.a = a;
    corners.b = b;
    corners.c = c;
    send_item(OP_TRIANGLE, IDX_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
              COORD_W'($urandom), corners, idle_ok);
  endtask

  task automatic settle();
    start <= 1'b0;
    while (verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_min_cos(input logic [CFG_W-1:0] value);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    min_cos_model = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(input string name, input int unsigned expected_value,
                             input int unsigned actual_value);
    if (expected_value != actual_value) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name,
               expected_value, actual_value);
      mismatch_count++;
    end
  endtask

  task automatic test_vertex_extremes();
    write_vertex(0, 0, 0, 0, 1'b1);
    write_vertex(4095, 32767, 0, 0, 1'b1);
    write_vertex(1, 0, 32767, 0, 1'b1);
    write_vertex(2, -32768, -32768, 32767, 1'b1);
    write_vertex(3, 0, 0, -32768, 1'b1);
    write_vertex(5, -1, -1, -1, 1'b1);
    write_vertex(6, -32768, 0, 0, 1'b1);
    write_vertex(7, 0, 100, 100, 1'b1);
    write_vertex(8, 0, 100, 101, 1'b1);
  endtask

  // runs under the reset value of the slope limit (45 degrees)
  task automatic test_reset_limit();
    classify(0, 4095, 1, 1'b1);
    classify(0, 1, 4095, 1'b1);
    classify(0, 4095, 3, 1'b1);
    classify(5, 5, 5, 1'b1);
    classify(0, 4095, 6, 1'b1);
    classify(0, 4095, 7, 1'b1);
    classify(0, 4095, 8, 1'b1);
    classify(2, 4095, 1, 1'b1);
  endtask

  task automatic test_limit_extremes();
    logic [CFG_W-1:0] settings [3];
    settings = '{CFG_W'(0), CFG_W'(65536), CFG_W'(131071)};
    foreach (settings[i]) begin
      set_min_cos(settings[i]);
      classify(0, 4095, 1, 1'b1);
      classify(0, 4095, 3, 1'b1);
      classify(5, 5, 5, 1'b1);
    end
  endtask

  task automatic random_phase(input logic [CFG_W-1:0] setting, input int count,
                              input bit idle_ok);
    logic [IDX_W-1:0] slot;
    logic [IDX_W-1:0] a;
    set_min_cos(setting);
    for (int n = 0; n < count; n++) begin
      if (written_slots.size() < 3 || $urandom_range(0, 99) < 35) begin
        if ($urandom_range(0, 3) == 0) begin
          slot = pick_slot();
        end else begin
          slot = IDX_W'($urandom);
        end
        write_vertex(slot, random_coord(), random_coord(), random_coord(), idle_ok);
      end else begin
        a = pick_slot();
        if ($urandom_range(0, 9) == 0) begin
          classify(a, pick_slot(), a, idle_ok);
        end else begin
          classify(a, pick_slot(), pick_slot(), idle_ok);
        end
      end
    end
  endtask

  task automatic test_random_mesh();
    random_phase(CFG_W'($urandom_range(0, 65536)), 300, 1'b1);
    random_phase(CFG_W'(65536), 100, 1'b1);
    random_phase(CFG_W'(0), 100, 1'b1);
    random_phase(CFG_W'(131071), 60, 1'b1);
    random_phase(CFG_W'($urandom_range(0, 131071)), 200, 1'b0);
    random_phase(CFG_W'($urandom_range(0, 65536)), 290, 1'b1);
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (verdicts.size() == 0) begin
        $display("%0t: unexpected result, expected none actual keep %0b corners %0d %0d %0d",
                 $time, keep_flag, out_corner_a, out_corner_b, out_corner_c);
        mismatch_count++;
      end else begin
        due_verdict = verdicts.pop_front();
        check_field("keep", 32'(due_verdict.keep), 32'(keep_flag));
        check_field("out_corner_a", 32'(due_verdict.corners.a), 32'(out_corner_a));
        check_field("out_corner_b", 32'(due_verdict.corners.b), 32'(out_corner_b));
        check_field("out_corner_c", 32'(due_verdict.corners.c), 32'(out_corner_c));
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("triangle_slope_filter_core_tb failed");
      $finish;
    end
  end

  initial begin
    rst         <= 1'b1;
    start       <= 1'b0;
    operation   <= OP_WRITE;
    vertex_slot <= '0;
    coord_x     <= '0;
    coord_y     <= '0;
    coord_z     <= '0;
    corner_a    <= '0;
    corner_b    <= '0;
    corner_c    <= '0;
    cfg_valid   <= 1'b0;
    cfg_data    <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_vertex_extremes();
    test_reset_limit();
    test_limit_extremes();
    test_random_mesh();
    settle();
    if (mismatch_count == 0 && verdicts.size() == 0) begin
      $display("triangle_slope_filter_core_tb passed");
    end else begin
      $display("triangle_slope_filter_core_tb failed");
    end
    $finish;
  end

endmodule

### filelist.f
sv/tsf_pkg.sv
sv/tsf_ram.sv
sv/triangle_slope_filter_core.sv
tb/triangle_slope_filter_core_tb.sv
